// ----- design/gda_pkg.sv -----
// Shared types, constants and calendar helpers for the Gregorian date adder.
// No dependencies; imported by the controller, the datapath and the top level.
package gda_pkg;

    localparam logic [13:0] YEAR_MIN  = 14'd1900;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [4:0]  DAY_MIN   = 5'd1;
    localparam logic [4:0]  DAY_MAX   = 5'd31;
    localparam logic [8:0]  DAYS_LEAP = 9'd366;
    localparam logic [8:0]  DAYS_NORM = 9'd365;
    localparam logic [4:0]  FEB_LEAP  = 5'd29;
    localparam logic [3:0]  FEBRUARY  = 4'd2;

    // 25 * 7209 == 1 mod 2^14: y is a multiple of 25 iff (y * 7209) mod 2^14 <= (2^14-1)/25
    localparam logic [13:0] INV25       = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_REPORT
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADV_INIT,
        CMD_YEAR_STEP,
        CMD_SATURATE,
        CMD_MONTH_STEP,
        CMD_FINISH,
        CMD_REPORT
    } cmd_t;

    typedef struct packed {
        logic year_over;    // remaining days exceed the current year
        logic year_at_max;  // current year is the last one allowed
        logic month_over;   // remaining days exceed the current month, which is not December
    } status_t;

    function automatic logic is_leap(input logic [13:0] y);
        logic [27:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = 28'(y) * 28'(INV25);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod[13:0] <= DIV25_LIMIT);
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:                    len = leap ? FEB_LEAP : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before m, common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- design/gda_ctrl.sv -----
// Sequencer for the date adder: accepts a transaction, steps the datapath through
// years and months, and hands the result to the output register. Uses gda_pkg.
module gda_ctrl
    import gda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    op,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = op ? ST_YEAR : ST_REPORT;
                end
            end
            ST_YEAR:
            begin
                if (status.year_over)
                begin
                    state_next = status.year_at_max ? ST_REPORT : ST_YEAR;
                end
                else
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (!status.month_over)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd = op ? CMD_ADV_INIT : CMD_LOAD;
                end
            end
            ST_YEAR:
            begin
                if (status.year_over)
                begin
                    cmd = status.year_at_max ? CMD_SATURATE : CMD_YEAR_STEP;
                end
            end
            ST_MONTH:
            begin
                cmd = status.month_over ? CMD_MONTH_STEP : CMD_FINISH;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    cmd = CMD_REPORT;
                end
            end
            default: cmd = CMD_NONE;
        endcase
    end

    always_comb
    begin
        if (cmd == CMD_REPORT)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // a new result never lands on one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_REPORT) |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

    // an accepted load moves straight to the report state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && !op) |=> (state_reg == ST_REPORT))
        else $error("load did not go straight to report");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("report did not raise out_valid");

endmodule

// ----- design/gda_datapath.sv -----
// Date registers, day counter and result register for the date adder.
// Driven by commands from gda_ctrl; uses gda_pkg for constants and calendar helpers.
module gda_datapath
    import gda_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [13:0]            in_year,
    input  logic [3:0]             in_month,
    input  logic [4:0]             in_day,
    input  logic [OFFSET_BITS-1:0] offset_days,
    output logic [13:0]            out_year,
    output logic [3:0]             out_month,
    output logic [4:0]             out_day,
    output logic [8:0]             day_of_year,
    output logic [8:0]             days_left,
    output logic                   leap_flag
);

    // room for the largest ordinal day plus the largest offset
    localparam int TOT_W = OFFSET_BITS + 2;

    logic [13:0]      year_reg,  year_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       day_reg,   day_next;
    logic             leap_reg,  leap_next;
    logic [TOT_W-1:0] total_reg, total_next;

    logic [13:0] o_year_reg;
    logic [3:0]  o_month_reg;
    logic [4:0]  o_day_reg;
    logic [8:0]  o_doy_reg;
    logic [8:0]  o_left_reg;
    logic        o_leap_reg;

    logic [13:0] ld_year;
    logic [3:0]  ld_month;
    logic [4:0]  ld_day;
    logic [4:0]  ld_mlen;
    logic [13:0] leap_arg;
    logic        leap_calc;
    logic [8:0]  cur_doy;
    logic [8:0]  year_len;
    logic [4:0]  cur_mlen;

    // year fed to the single leap unit: the clamped load year or the next year
    assign leap_arg  = (cmd == CMD_LOAD) ? ld_year : (year_reg + 14'd1);
    assign leap_calc = is_leap(leap_arg);

    always_comb
    begin
        if (in_month < MONTH_MIN)
        begin
            ld_month = MONTH_MIN;
        end
        else if (in_month > MONTH_MAX)
        begin
            ld_month = MONTH_MAX;
        end
        else
        begin
            ld_month = in_month;
        end

        if (in_year < YEAR_MIN)
        begin
            ld_year = YEAR_MIN;
        end
        else if (in_year > YEAR_MAX)
        begin
            ld_year = YEAR_MAX;
        end
        else
        begin
            ld_year = in_year;
        end
    end

    // day clamp needs the leap flag of the clamped year
    always_comb
    begin
        ld_mlen = month_len(leap_calc, ld_month);
        if (in_day < DAY_MIN)
        begin
            ld_day = DAY_MIN;
        end
        else if (in_day > ld_mlen)
        begin
            ld_day = ld_mlen;
        end
        else
        begin
            ld_day = in_day;
        end
    end

    assign year_len = leap_reg ? DAYS_LEAP : DAYS_NORM;
    assign cur_mlen = month_len(leap_reg, month_reg);
    assign cur_doy  = days_before(month_reg)
                    + 9'((leap_reg && month_reg > FEBRUARY) ? 1 : 0)
                    + 9'(day_reg);

    assign status.year_over   = total_reg > TOT_W'(year_len);
    assign status.year_at_max = year_reg >= YEAR_MAX;
    assign status.month_over  = (month_reg < MONTH_MAX) && (total_reg > TOT_W'(cur_mlen));

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        leap_next  = leap_reg;
        total_next = total_reg;
        case (cmd)
            CMD_LOAD:
            begin
                year_next  = ld_year;
                month_next = ld_month;
                day_next   = ld_day;
                leap_next  = leap_calc;
            end
            CMD_ADV_INIT:
            begin
                total_next = TOT_W'(cur_doy) + TOT_W'(offset_days);
                month_next = MONTH_MIN;
            end
            CMD_YEAR_STEP:
            begin
                total_next = total_reg - TOT_W'(year_len);
                year_next  = year_reg + 14'd1;
                leap_next  = leap_calc;
            end
            CMD_SATURATE:
            begin
                year_next  = YEAR_MAX;
                month_next = MONTH_MAX;
                day_next   = DAY_MAX;
                leap_next  = is_leap(YEAR_MAX);
            end
            CMD_MONTH_STEP:
            begin
                total_next = total_reg - TOT_W'(cur_mlen);
                month_next = month_reg + 4'd1;
            end
            CMD_FINISH:
            begin
                day_next = total_reg[4:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= YEAR_MIN;
            month_reg <= MONTH_MIN;
            day_reg   <= DAY_MIN;
            leap_reg  <= 1'b0;
        end
        else
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            leap_reg  <= leap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        if (cmd == CMD_REPORT)
        begin
            o_year_reg  <= year_reg;
            o_month_reg <= month_reg;
            o_day_reg   <= day_reg;
            o_doy_reg   <= cur_doy;
            o_left_reg  <= year_len - cur_doy;
            o_leap_reg  <= leap_reg;
        end
    end

    assign out_year    = o_year_reg;
    assign out_month   = o_month_reg;
    assign out_day     = o_day_reg;
    assign day_of_year = o_doy_reg;
    assign days_left   = o_left_reg;
    assign leap_flag   = o_leap_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        leap_reg == is_leap(year_reg))
        else $error("leap flag out of step with year");

    assert property (@(posedge clk) disable iff (!rst_n)
        (year_reg >= YEAR_MIN) && (year_reg <= YEAR_MAX)
        && (month_reg >= MONTH_MIN) && (month_reg <= MONTH_MAX))
        else $error("stored date out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_YEAR_STEP) |=> (year_reg == $past(year_reg) + 14'd1))
        else $error("year step did not advance the year");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_REPORT) |-> (day_reg >= DAY_MIN) && (day_reg <= cur_mlen))
        else $error("reported day past end of month");

endmodule

// ----- design/gregorian_date_add_days_top.sv -----
// Gregorian date register with day advance: a load (op 0) stores a clamped date, an
// advance (op 1) moves the stored date forward by offset_days. Each transaction yields
// one result: date, ordinal day, days left in the year and the leap flag. A load
// goes from acceptance through the report state into the result register. An advance
// runs the year loop, subtracting one year length per cycle, then walks at most 11
// months of the final year, sets the day and reports. Saturation at 9999-12-31 ends
// the walk early. The result register lets the next transaction be accepted while a
// result waits.
// Depends on gda_pkg, gda_ctrl and gda_datapath.
module gregorian_date_add_days_top
    import gda_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [13:0]            in_year,
    input  logic [3:0]             in_month,
    input  logic [4:0]             in_day,
    input  logic [OFFSET_BITS-1:0] offset_days,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [13:0]            out_year,
    output logic [3:0]             out_month,
    output logic [4:0]             out_day,
    output logic [8:0]             day_of_year,
    output logic [8:0]             days_left,
    output logic                   leap_flag
);

    cmd_t    cmd;
    status_t status;

    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gda_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_year     (in_year),
        .in_month    (in_month),
        .in_day      (in_day),
        .offset_days (offset_days),
        .out_year    (out_year),
        .out_month   (out_month),
        .out_day     (out_day),
        .day_of_year (day_of_year),
        .days_left   (days_left),
        .leap_flag   (leap_flag)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for gregorian_date_add_days_top: loads and day advances.
// Holds its own calendar predictor; depends on gda_pkg and the RTL top level only.
module tb
    import gda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFF_W          = 16;
    localparam int RANDOM_ITEMS   = 1925;
    localparam int IDLE_PCT       = 15;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 400;
    localparam int CALM_FROM      = 1000;
    localparam int CALM_TO        = 1300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic             op;
        logic [13:0]      year;
        logic [3:0]       month;
        logic [4:0]       day;
        logic [OFF_W-1:0] offset;
    } date_req_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
        logic [8:0]  left;
        logic        leap;
    } date_res_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic             op          = OP_LOAD;
    logic [13:0]      in_year     = '0;
    logic [3:0]       in_month    = '0;
    logic [4:0]       in_day      = '0;
    logic [OFF_W-1:0] offset_days = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [13:0]      out_year;
    logic [3:0]       out_month;
    logic [4:0]       out_day;
    logic [8:0]       day_of_year;
    logic [8:0]       days_left;
    logic             leap_flag;

    date_req_t pending_reqs[$];
    date_res_t expected_dates[$];
    date_req_t offered;

    // predictor state
    int cal_year  = 1900;
    int cal_month = 1;
    int cal_day   = 1;

    int total_items    = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int err_count      = 0;
    int load_count     = 0;
    int advance_count  = 0;
    int sat_count      = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int idle_cycles    = 0;

    gregorian_date_add_days_top #(.OFFSET_BITS(OFF_W)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .in_year     (in_year),
        .in_month    (in_month),
        .in_day      (in_day),
        .offset_days (offset_days),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_year    (out_year),
        .out_month   (out_month),
        .out_day     (out_day),
        .day_of_year (day_of_year),
        .days_left   (days_left),
        .leap_flag   (leap_flag)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit leap_year(int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int year_days(int y);
        return leap_year(y) ? int'(DAYS_LEAP) : int'(DAYS_NORM);
    endfunction

    function automatic int days_in_month(int y, int m);
        int len;
        case (m)
            int'(FEBRUARY): len = leap_year(y) ? int'(FEB_LEAP) : 28;
            4, 6, 9, 11:    len = 30;
            default:        len = 31;
        endcase
        return len;
    endfunction

    function automatic int ordinal_of(int y, int m, int d);
        int total;
        total = d;
        for (int i = 1; i < m; i++)
            total += days_in_month(y, i);
        return total;
    endfunction

    // Applies one transaction to the predicted calendar and returns the result it yields.
    function automatic date_res_t calendar_step(date_req_t r);
        date_res_t res;
        int        y;
        int        m;
        int        d;
        int        total;
        bit        sat;
        if (r.op == OP_LOAD)
        begin
            load_count++;
            y = int'(r.year);
            m = int'(r.month);
            d = int'(r.day);
            if (m < int'(MONTH_MIN)) m = int'(MONTH_MIN);
            else if (m > int'(MONTH_MAX)) m = int'(MONTH_MAX);
            if (y < int'(YEAR_MIN)) y = int'(YEAR_MIN);
            else if (y > int'(YEAR_MAX)) y = int'(YEAR_MAX);
            // year is clamped first so February gets the right length
            if (d < int'(DAY_MIN)) d = int'(DAY_MIN);
            else if (d > days_in_month(y, m)) d = days_in_month(y, m);
            cal_year  = y;
            cal_month = m;
            cal_day   = d;
        end
        else
        begin
            advance_count++;
            total = ordinal_of(cal_year, cal_month, cal_day) + int'(r.offset);
            y     = cal_year;
            m     = 1;
            sat   = 1'b0;
            while (!sat && total > year_days(y))
            begin
                if (y >= int'(YEAR_MAX))
                    sat = 1'b1;
                else
                begin
                    total -= year_days(y);
                    y++;
                end
            end
            if (sat)
            begin
                sat_count++;
                cal_year  = int'(YEAR_MAX);
                cal_month = int'(MONTH_MAX);
                cal_day   = int'(DAY_MAX);
            end
            else
            begin
                while (m < int'(MONTH_MAX) && total > days_in_month(y, m))
                begin
                    total -= days_in_month(y, m);
                    m++;
                end
                cal_year  = y;
                cal_month = m;
                cal_day   = total;
            end
        end
        res.year  = cal_year[13:0];
        res.month = cal_month[3:0];
        res.day   = cal_day[4:0];
        total     = ordinal_of(cal_year, cal_month, cal_day);
        res.doy   = total[8:0];
        total     = year_days(cal_year) - total;
        res.left  = total[8:0];
        res.leap  = leap_year(cal_year);
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d",
                 checked_count, field, got, want);
        err_count++;
    endtask

    task automatic add_load(int y, int m, int d);
        date_req_t r;
        r.op     = OP_LOAD;
        r.year   = y[13:0];
        r.month  = m[3:0];
        r.day    = d[4:0];
        r.offset = OFF_W'($urandom());
        pending_reqs.push_back(r);
    endtask

    task automatic add_advance(int days);
        date_req_t r;
        r.op     = OP_ADVANCE;
        r.year   = 14'($urandom());
        r.month  = 4'($urandom());
        r.day    = 5'($urandom());
        r.offset = days[OFF_W-1:0];
        pending_reqs.push_back(r);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            op          <= OP_LOAD;
            in_year     <= '0;
            in_month    <= '0;
            in_day      <= '0;
            offset_days <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_dates.push_back(calendar_step(offered));
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 &&
                    ((accepted_count >= CALM_FROM && accepted_count < CALM_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    offered      = pending_reqs.pop_front();
                    op          <= offered.op;
                    in_year     <= offered.year;
                    in_month    <= offered.month;
                    in_day      <= offered.day;
                    offset_days <= offered.offset;
                    in_valid    <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks results and drives the stall, including one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked_count++;
                if (expected_dates.size() == 0)
                    report_mismatch("unexpected out_year", int'(out_year), 0);
                else
                begin
                    date_res_t want;
                    want = expected_dates.pop_front();
                    if (out_year != want.year)
                        report_mismatch("out_year", int'(out_year), int'(want.year));
                    if (out_month != want.month)
                        report_mismatch("out_month", int'(out_month), int'(want.month));
                    if (out_day != want.day)
                        report_mismatch("out_day", int'(out_day), int'(want.day));
                    if (day_of_year != want.doy)
                        report_mismatch("day_of_year", int'(day_of_year), int'(want.doy));
                    if (days_left != want.left)
                        report_mismatch("days_left", int'(days_left), int'(want.left));
                    if (leap_flag != want.leap)
                        report_mismatch("leap_flag", int'(leap_flag), int'(want.leap));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && checked_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !(checked_count >= CALM_FROM && checked_count < CALM_TO) &&
                             ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Timeout: no transaction for %0d cycles", idle_cycles);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int y;
        int m;
        int d;
        int days;

        // directed: clamping on load, leap rules, year ends, saturation, zero offset
        add_advance(0);
        add_load(0, 0, 0);
        add_load(16383, 15, 31);
        add_advance(1);
        add_load(2000, 2, 31);
        add_load(1900, 2, 30);
        add_load(2100, 2, 29);
        add_load(2023, 2, 29);
        add_advance(1);
        add_load(2024, 2, 28);
        add_advance(1);
        add_advance(1);
        add_load(2024, 12, 31);
        add_advance(1);
        add_load(8191, 4, 31);
        add_advance(0);
        add_load(1900, 1, 1);
        add_advance(65535);
        add_load(9999, 1, 1);
        add_advance(364);
        add_advance(1);
        add_load(9900, 6, 15);
        add_advance(65535);
        add_load(1899, 13, 16);
        add_advance(32768);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 9))
                    0:       y = $urandom_range(0, 16383);
                    1, 2:    y = $urandom_range(9980, 9999);
                    3:       y = $urandom_range(19, 99) * 100;
                    4:       y = $urandom_range(0, 1899);
                    default: y = $urandom_range(1900, 9999);
                endcase
                m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) :
                                                  $urandom_range(1, 12);
                d = $urandom_range(0, 31);
                add_load(y, m, d);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: days = $urandom_range(0, 400);
                    3, 4:    days = $urandom_range(0, 3000);
                    5:       days = $urandom_range(0, 65535);
                    6:       days = $urandom_range(65000, 65535);
                    7:       days = $urandom_range(0, 1);
                    default: days = $urandom_range(28, 370);
                endcase
                add_advance(days);
            end
        end
        total_items = pending_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (accepted_count < total_items || expected_dates.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d loads and %0d advances",
                 checked_count, load_count, advance_count);
        $display("%0d advances saturated at the last year; one long output hold-off",
                 sat_count);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
